### rtl/fpa_pkg.sv
// package for the q24.8 fixed-point alu: mode codes, defaults and the cell beat type
package fpa_pkg;

   localparam int DefFracBits = 8;

   typedef enum logic [3:0] {
      MODE_ADD      = 4'd0,
      MODE_SUB      = 4'd1,
      MODE_MUL      = 4'd2,
      MODE_DIV      = 4'd3,
      MODE_GT       = 4'd4,
      MODE_GE       = 4'd5,
      MODE_LT       = 4'd6,
      MODE_LE       = 4'd7,
      MODE_EQ       = 4'd8,
      MODE_NE       = 4'd9,
      MODE_MIN      = 4'd10,
      MODE_MAX      = 4'd11,
      MODE_INC      = 4'd12,
      MODE_DEC      = 4'd13,
      MODE_FROM_INT = 4'd14,
      MODE_TO_INT   = 4'd15
   } mode_type;

   // one beat moving down the divider row
   typedef struct packed {
      logic        valid;
      logic        div_op;
      logic        neg;
      logic        dz;
      logic        cmp;
      logic [31:0] res;
      logic [31:0] rem;
      logic [31:0] dvs;
   } cell_type;

endpackage

### rtl/fixed_point_q24_8_alu_unit.sv
// top level of the fixed-point alu: decode stage, divider cell row, output register
//
//  channel | direction | ports
//  req     | in        | req_valid req_ready req_mode req_operand_a req_operand_b
//  rsp     | out       | rsp_valid rsp_ready rsp_result_value rsp_compare_true
//          |           | rsp_divide_by_zero
//
// one beat enters per cycle while the pipeline advances; an accepted beat passes the
// decode stage register, the row of one-bit division cells and the output register,
// as all beats do. the whole pipeline moves as one; it holds while a result waits
// and rsp_ready is low. reset clears only the valid bits of the stages.
module fixed_point_q24_8_alu_unit #(
   parameter int FRAC_BITS = fpa_pkg::DefFracBits
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fpa_pkg::mode_type   req_mode,
   input  logic signed [31:0]  req_operand_a,
   input  logic signed [31:0]  req_operand_b,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_result_value,
   output logic                rsp_compare_true,
   output logic                rsp_divide_by_zero
);
   import fpa_pkg::*;

   localparam int DivW = 32 + FRAC_BITS;

   logic             advance;
   cell_type         head_ff, head_in;
   logic [DivW-1:0]  hwork_ff, hwork_in;
   cell_type         chain_cell [DivW+1];
   logic [DivW-1:0]  chain_work [DivW+1];
   logic signed [63:0] prod;
   logic [31:0]      ma, mb;
   logic             rsp_valid_ff;
   logic [31:0]      res_ff, res_in;
   logic             cmp_ff, dz_ff;
   cell_type         tail;
   logic [31:0]      quo;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // decode: simple modes and the multiply finish here, divide is set up
   always_comb begin
      prod = 64'(req_operand_a) * 64'(req_operand_b);
      ma   = req_operand_a[31] ? 32'(-req_operand_a) : 32'(req_operand_a);
      mb   = req_operand_b[31] ? 32'(-req_operand_b) : 32'(req_operand_b);
      head_in        = '0;
      head_in.valid  = req_valid;
      head_in.dvs    = mb;
      head_in.neg    = req_operand_a[31] ^ req_operand_b[31];
      hwork_in       = {ma, {FRAC_BITS{1'b0}}};
      case (req_mode)
         MODE_ADD:      head_in.res = req_operand_a + req_operand_b;
         MODE_SUB:      head_in.res = req_operand_a - req_operand_b;
         MODE_MUL:      head_in.res = 32'(prod >>> FRAC_BITS);
         MODE_DIV: begin
            head_in.div_op = (req_operand_b != 32'sd0);
            head_in.dz     = (req_operand_b == 32'sd0);
         end
         MODE_GT:       head_in.cmp = req_operand_a >  req_operand_b;
         MODE_GE:       head_in.cmp = req_operand_a >= req_operand_b;
         MODE_LT:       head_in.cmp = req_operand_a <  req_operand_b;
         MODE_LE:       head_in.cmp = req_operand_a <= req_operand_b;
         MODE_EQ:       head_in.cmp = req_operand_a == req_operand_b;
         MODE_NE:       head_in.cmp = req_operand_a != req_operand_b;
         MODE_MIN:      head_in.res = (req_operand_a > req_operand_b) ?
                                      req_operand_b : req_operand_a;
         MODE_MAX:      head_in.res = (req_operand_a < req_operand_b) ?
                                      req_operand_b : req_operand_a;
         MODE_INC:      head_in.res = req_operand_a + 32'sd1;
         MODE_DEC:      head_in.res = req_operand_a - 32'sd1;
         MODE_FROM_INT: head_in.res = req_operand_a << FRAC_BITS;
         MODE_TO_INT:   head_in.res = req_operand_a >>> FRAC_BITS;
         default:       head_in.res = '0;
      endcase
   end

   // decode stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff.valid <= head_in.valid;
      end
      if (advance) begin
         head_ff.div_op <= head_in.div_op;
         head_ff.neg    <= head_in.neg;
         head_ff.dz     <= head_in.dz;
         head_ff.cmp    <= head_in.cmp;
         head_ff.res    <= head_in.res;
         head_ff.rem    <= head_in.rem;
         head_ff.dvs    <= head_in.dvs;
         hwork_ff       <= hwork_in;
      end
   end

   assign chain_cell[0] = head_ff;
   assign chain_work[0] = hwork_ff;

   // row of division cells, one quotient bit each
   for (genvar i = 0; i < DivW; i++) begin : g_cell
      fpa_div_cell #(.DIV_W(DivW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cell_i  (chain_cell[i]),
         .work_i  (chain_work[i]),
         .cell_o  (chain_cell[i+1]),
         .work_o  (chain_work[i+1])
      );
   end

   // sign fix of the quotient and final select
   always_comb begin
      tail   = chain_cell[DivW];
      quo    = chain_work[DivW][31:0];
      res_in = tail.res;
      if (tail.div_op) begin
         res_in = tail.neg ? 32'(-quo) : quo;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.valid;
      end
      if (advance) begin
         res_ff <= res_in;
         cmp_ff <= tail.cmp;
         dz_ff  <= tail.dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = res_ff;
   assign rsp_compare_true   = cmp_ff;
   assign rsp_divide_by_zero = dz_ff;

   // checks
   a_zero_div_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> res_ff == 32'd0 && !cmp_ff)
      else $error("zero divisor result not clean");
   a_cmp_zero_res: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> res_ff == 32'd0 && !dz_ff)
      else $error("comparison result not zero");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_ff))
      else $error("pipeline moved during stall");

endmodule

### rtl/fpa_div_cell.sv
// one restoring-division cell: takes one dividend bit, yields one quotient bit
module fpa_div_cell #(
   parameter int DIV_W = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  fpa_pkg::cell_type cell_i,
   input  logic [DIV_W-1:0]  work_i,
   output fpa_pkg::cell_type cell_o,
   output logic [DIV_W-1:0]  work_o
);
   import fpa_pkg::*;

   cell_type         cell_ff, cell_in;
   logic [DIV_W-1:0] work_ff, work_in;
   logic [32:0]      trial;
   logic [32:0]      diff;
   logic             ge;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      trial   = {cell_i.rem, work_i[DIV_W-1]};
      diff    = trial - {1'b0, cell_i.dvs};
      ge      = !diff[32];
      cell_in = cell_i;
      cell_in.rem = ge ? diff[31:0] : trial[31:0];
      work_in = {work_i[DIV_W-2:0], ge};
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (advance) begin
         cell_ff.div_op <= cell_in.div_op;
         cell_ff.neg    <= cell_in.neg;
         cell_ff.dz     <= cell_in.dz;
         cell_ff.cmp    <= cell_in.cmp;
         cell_ff.res    <= cell_in.res;
         cell_ff.rem    <= cell_in.rem;
         cell_ff.dvs    <= cell_in.dvs;
         work_ff        <= work_in;
      end
   end

   assign cell_o = cell_ff;
   assign work_o = work_ff;

endmodule

### test/fixed_point_q24_8_alu_unit_tb.sv
// testbench for the q24.8 fixed-point alu: directed and random beats checked against a predictor
module fixed_point_q24_8_alu_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fpa_pkg::*;

   localparam int FracBits = DefFracBits;
   localparam int Latency  = 32 + FracBits + 2;

   typedef struct packed {
      logic [31:0] value;
      logic        cmp;
      logic        dz;
   } alu_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   mode_type           req_mode;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_result_value;
   logic               rsp_compare_true;
   logic               rsp_divide_by_zero;

   alu_result_type pending_results[$];
   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          recv_hold_cycles = 0;

   fixed_point_q24_8_alu_unit #(.FRAC_BITS(FracBits)) dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // predicted outcome of one operation
   function automatic alu_result_type alu_predict(mode_type m, logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type     r;
      logic signed [63:0] prod;
      logic [63:0]        mag_a;
      logic [63:0]        mag_b;
      logic [63:0]        quot;
      r = '0;
      case (m)
         MODE_ADD: r.value = a + b;
         MODE_SUB: r.value = a - b;
         MODE_MUL: begin
            prod = 64'(a) * 64'(b);
            prod = prod >>> FracBits;
            r.value = prod[31:0];
         end
         MODE_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               mag_a = a[31] ? -64'(a) : 64'(a);
               mag_b = b[31] ? -64'(b) : 64'(b);
               quot = (mag_a << FracBits) / mag_b;
               if (a[31] != b[31]) quot = -quot;
               r.value = quot[31:0];
            end
         end
         MODE_GT:  r.cmp = a > b;
         MODE_GE:  r.cmp = a >= b;
         MODE_LT:  r.cmp = a < b;
         MODE_LE:  r.cmp = a <= b;
         MODE_EQ:  r.cmp = a == b;
         MODE_NE:  r.cmp = a != b;
         MODE_MIN: r.value = (a > b) ? b : a;
         MODE_MAX: r.value = (a < b) ? b : a;
         MODE_INC: r.value = a + 32'sd1;
         MODE_DEC: r.value = a - 32'sd1;
         MODE_FROM_INT: r.value = a << FracBits;
         default:  r.value = a >>> FracBits;
      endcase
      return r;
   endfunction

   // send one beat, with optional idle cycles before it; otherwise valid stays up between beats
   task automatic send_op(mode_type m, logic signed [31:0] a, logic signed [31:0] b);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(alu_predict(m, a, b));
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         recv_hold_cycles <= recv_hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      alu_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat value=%h", rsp_result_value);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_value !== want.value) begin
               $error("result_value expected %h actual %h", want.value, rsp_result_value);
               error_count++;
            end
            if (rsp_compare_true !== want.cmp) begin
               $error("compare_true expected %b actual %b", want.cmp, rsp_compare_true);
               error_count++;
            end
            if (rsp_divide_by_zero !== want.dz) begin
               $error("divide_by_zero expected %b actual %b", want.dz, rsp_divide_by_zero);
               error_count++;
            end
         end
      end
   end

   // drop valid and wait until every expected result has come
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed(32'($urandom_range(2047)) - 32'd1024);
         3: return 32'sd0;
         default: return $signed($urandom());
      endcase
   endfunction

   // extremes of the fields and every mode
   task automatic test_directed();
      logic signed [31:0] max_v;
      logic signed [31:0] min_v;
      max_v = 32'sh7fffffff;
      min_v = 32'sh80000000;
      send_op(MODE_ADD, max_v, 32'sd1);
      send_op(MODE_SUB, min_v, 32'sd1);
      send_op(MODE_MUL, max_v, max_v);
      send_op(MODE_MUL, min_v, 32'sh100);
      send_op(MODE_MUL, -32'sd384, 32'sd640);
      send_op(MODE_DIV, 32'sh100, 32'sd0);
      send_op(MODE_DIV, max_v, 32'sd1);
      send_op(MODE_DIV, min_v, -32'sd1);
      send_op(MODE_DIV, -32'sd768, 32'sd512);
      send_op(MODE_GT, min_v, max_v);
      send_op(MODE_GE, max_v, max_v);
      send_op(MODE_LT, -32'sd1, 32'sd0);
      send_op(MODE_LE, 32'sd5, 32'sd4);
      send_op(MODE_EQ, min_v, min_v);
      send_op(MODE_NE, 32'sd3, 32'sd3);
      send_op(MODE_MIN, max_v, min_v);
      send_op(MODE_MAX, min_v, max_v);
      send_op(MODE_INC, max_v, 32'sd0);
      send_op(MODE_DEC, min_v, -32'sd1);
      send_op(MODE_FROM_INT, max_v, 32'sd0);
      send_op(MODE_TO_INT, -32'sd1, 32'sd0);
      send_op(MODE_TO_INT, min_v, max_v);
      wait_drained();
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         send_op(mode_type'($urandom_range(15)), pick_operand(), pick_operand());
      end
      send_idle_pct = 0;
   endtask

   // long receiver hold while the sender keeps offering, then a full drain
   task automatic test_backpressure();
      recv_stall_pct   = 0;
      recv_hold_cycles = 3 * Latency;
      test_random(2 * Latency, 0, 0);
      wait_drained();
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_mode      <= MODE_ADD;
      req_operand_a <= '0;
      req_operand_b <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(100, 0, 0);
      test_random(100, 51, 0);
      test_random(100, 0, 51);
      test_random(100, 26, 26);
      test_backpressure();
      recv_stall_pct = 0;
      @(posedge clock);
      wait_drained();
      repeat (Latency + 10) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // timeout
   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
